/* sv/mtwg_pkg.sv */
package mtwg_pkg;

    // generator dimensions
    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int MAX_BURST    = 64;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;
    localparam int IDX_W   = 10;

    // read index codes above the last state word, and the last state index
    localparam logic [IDX_W-1:0] NEED_TWIST = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0] NEED_SEED  = IDX_W'(STATE_WORDS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STATE_WORDS - 1);

    // recurrence, twist and tempering constants
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] SEED_DEFAULT = 32'd5489;
    localparam logic [WORD_W-1:0] TWIST_XOR    = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_SEED,
        ST_TW_PRIME,
        ST_TWIST,
        ST_TW_END
    } mtwg_state_t;

    // output tempering
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

/* sv/mtwg_if.sv */
interface mtwg_req_if;
    logic                        valid;
    logic                        ready;
    logic [mtwg_pkg::COUNT_W-1:0] word_count;

    modport source (output valid, output word_count, input ready);
    modport sink   (input valid, input word_count, output ready);
endinterface

interface mtwg_word_if;
    logic                       valid;
    logic                       ready;
    logic [mtwg_pkg::WORD_W-1:0] random_word;
    logic                       last_word;

    modport source (output valid, output random_word, output last_word, input ready);
    modport sink   (input valid, input random_word, input last_word, output ready);
endinterface

/* sv/mersenne_twister_word_generator_core.sv */
// channel  | role   | payload                  | handshake
// ---------+--------+--------------------------+-------------
// req      | sink   | word_count (7b)          | valid/ready
// words    | source | random_word (32b), last  | valid/ready
// seed     | write  | seed_data (32b)          | seed_we
//
// a request of n words streams out at one word per cycle once the state is ready
// and the output is not stalled, the rate being set by the single read port that
// fetches state words. the first word after reset or a seed write waits for a fill
// (one multiply per cycle) and a twist (one state word per cycle). every 624 words
// a further twist of the state memory runs.
// a stalled output holds two words and stops further state reads; a new request
// is taken once the previous one has issued all its reads.
module mersenne_twister_word_generator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seed_we,
    input  logic [mtwg_pkg::WORD_W-1:0] seed_data,
    mtwg_req_if.sink                    req,
    mtwg_word_if.source                 words
);
    import mtwg_pkg::*;

    mtwg_state_t state_reg, state_next;

    logic [WORD_W-1:0]  seed_reg;
    logic [IDX_W-1:0]   read_index_reg, read_index_next;
    logic [COUNT_W-1:0] remaining_reg, remaining_next;
    logic [IDX_W-1:0]   seed_cnt_reg, seed_cnt_next;
    logic [WORD_W-1:0]  seed_prev_reg, seed_prev_next;
    logic [IDX_W-1:0]   tw_k_reg, tw_k_next;
    logic [IDX_W-1:0]   tw_wk_reg;
    logic               tw_v_reg;
    logic               prime_v_reg;
    logic [WORD_W-1:0]  cur_reg;

    logic [WORD_W-1:0]  mem [STATE_WORDS];
    logic [WORD_W-1:0]  rdata_a_reg, rdata_b_reg;
    logic [IDX_W-1:0]   addr_a, addr_b;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;

    logic               req_take;
    logic [COUNT_W-1:0] burst;
    logic               issue, issue_last, space;
    logic [IDX_W-1:0]   tw_nxt, tw_far;
    logic [WORD_W-1:0]  seed_mix, seed_val;
    logic [WORD_W-1:0]  tw_y, tw_val;

    // request intake with burst clamp
    assign req.ready = (state_reg == ST_IDLE);
    assign req_take  = req.valid && req.ready;
    assign burst     = (req.word_count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST)
                                                              : req.word_count;

    // neighbour addresses of the twist step, wrapped round the state
    assign tw_nxt = (tw_k_reg == LAST_IDX) ? '0 : tw_k_reg + 1'b1;
    assign tw_far = (tw_k_reg >= IDX_W'(STATE_WORDS - SHIFT_OFFSET))
                  ? tw_k_reg - IDX_W'(STATE_WORDS - SHIFT_OFFSET)
                  : tw_k_reg + IDX_W'(SHIFT_OFFSET);

    // seed fill recurrence, one word per cycle
    assign seed_mix = seed_prev_reg ^ (seed_prev_reg >> 30);
    assign seed_val = (seed_cnt_reg == '0) ? seed_reg
                    : SEED_MULT * seed_mix + WORD_W'(seed_cnt_reg);

    // twist of one word from the old current, old next and far word
    assign tw_y   = {cur_reg[WORD_W-1], rdata_a_reg[WORD_W-2:0]};
    assign tw_val = rdata_b_reg ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_XOR : '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take && burst != '0)
                    state_next = ST_GEN;
            end
            ST_GEN:
            begin
                if (read_index_reg >= NEED_SEED)
                    state_next = ST_SEED;
                else if (read_index_reg == NEED_TWIST)
                    state_next = ST_TW_PRIME;
                else if (space && remaining_reg == COUNT_W'(1))
                    state_next = ST_IDLE;
            end
            ST_SEED:
            begin
                if (seed_cnt_reg == LAST_IDX)
                    state_next = ST_TW_PRIME;
            end
            ST_TW_PRIME:
                state_next = ST_TWIST;
            ST_TWIST:
            begin
                if (tw_k_reg == LAST_IDX)
                    state_next = ST_TW_END;
            end
            ST_TW_END:
                state_next = ST_GEN;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and counters of the sequencer
    always_comb
    begin
        issue           = 1'b0;
        issue_last      = 1'b0;
        addr_a          = read_index_reg;
        addr_b          = tw_far;
        read_index_next = read_index_reg;
        remaining_next  = remaining_reg;
        seed_cnt_next   = seed_cnt_reg;
        seed_prev_next  = seed_prev_reg;
        tw_k_next       = tw_k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                    remaining_next = burst;
                seed_cnt_next = '0;
            end
            ST_GEN:
            begin
                seed_cnt_next = '0;
                if (read_index_reg < NEED_TWIST && space)
                begin
                    issue           = 1'b1;
                    issue_last      = (remaining_reg == COUNT_W'(1));
                    read_index_next = read_index_reg + 1'b1;
                    remaining_next  = remaining_reg - 1'b1;
                end
            end
            ST_SEED:
            begin
                seed_cnt_next  = seed_cnt_reg + 1'b1;
                seed_prev_next = seed_val;
            end
            ST_TW_PRIME:
            begin
                addr_a    = '0;
                tw_k_next = '0;
            end
            ST_TWIST:
            begin
                addr_a    = tw_nxt;
                tw_k_next = tw_k_reg + 1'b1;
            end
            ST_TW_END:
                read_index_next = '0;
            default:
            begin
                addr_a = read_index_reg;
            end
        endcase
        if (seed_we)
            read_index_next = NEED_SEED;
    end

    // single write port shared by the fill and the twist
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = seed_cnt_reg;
        mem_wdata = seed_val;
        if (tw_v_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = tw_wk_reg;
            mem_wdata = tw_val;
        end
        else if (state_reg == ST_SEED)
        begin
            mem_we = 1'b1;
        end
    end

    // state memory, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_a_reg <= mem[addr_a];
        rdata_b_reg <= mem[addr_b];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seed_reg       <= SEED_DEFAULT;
            read_index_reg <= NEED_SEED;
            remaining_reg  <= '0;
            tw_v_reg       <= 1'b0;
            prime_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            read_index_reg <= read_index_next;
            remaining_reg  <= remaining_next;
            tw_v_reg       <= (state_reg == ST_TWIST);
            prime_v_reg    <= (state_reg == ST_TW_PRIME);
            if (seed_we)
                seed_reg <= seed_data;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        seed_cnt_reg  <= seed_cnt_next;
        seed_prev_reg <= seed_prev_next;
        tw_k_reg      <= tw_k_next;
        tw_wk_reg     <= tw_k_reg;
        if (prime_v_reg || tw_v_reg)
            cur_reg <= rdata_a_reg;
    end

    // tempering and output queue
    mtwg_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .issue_last (issue_last),
        .rd_data    (rdata_a_reg),
        .space      (space),
        .words      (words)
    );

    // word reads never overlap a write into the state
    a_no_read_during_write: assert property (
        @(posedge clk) disable iff (!rst_n) !(issue && mem_we))
        else $error("state read issued while state is being rewritten");

    // reads only target a live state word
    a_issue_in_range: assert property (
        @(posedge clk) disable iff (!rst_n) issue |-> (read_index_reg < NEED_TWIST))
        else $error("word read issued with stale state");

    // a finished twist restarts the read index
    a_twist_restart: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TW_END && !seed_we) |=> (read_index_reg == '0))
        else $error("read index not cleared after twist");

    // a seed write always forces a refill
    a_seed_refill: assert property (
        @(posedge clk) disable iff (!rst_n) seed_we |=> (read_index_reg == NEED_SEED))
        else $error("seed write did not force a refill");

endmodule

/* sv/mtwg_out_buf.sv */
module mtwg_out_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        issue,
    input  logic                        issue_last,
    input  logic [mtwg_pkg::WORD_W-1:0] rd_data,
    output logic                        space,
    mtwg_word_if.source                 words
);
    import mtwg_pkg::*;

    logic              infl_reg, infl_next;
    logic              infl_last_reg, infl_last_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [WORD_W-1:0] word0_reg, word0_next;
    logic [WORD_W-1:0] word1_reg, word1_next;
    logic              last0_reg, last0_next;
    logic              last1_reg, last1_next;
    logic              pop;
    logic [1:0]        kept;
    logic [WORD_W-1:0] tempered;

    // head of the two-entry queue drives the port
    assign words.valid       = (cnt_reg != 2'd0);
    assign words.random_word = word0_reg;
    assign words.last_word   = last0_reg;
    assign pop               = words.valid && words.ready;

    // a read may go out when its word is sure of a slot
    assign space = ((cnt_reg + {1'b0, infl_reg}) < 2'd2) || pop;

    assign tempered = temper(rd_data);

    // queue update: shift on pop, returning word lands behind what is kept
    always_comb
    begin
        infl_next      = issue;
        infl_last_next = issue_last;
        word0_next     = word0_reg;
        word1_next     = word1_reg;
        last0_next     = last0_reg;
        last1_next     = last1_reg;
        kept           = cnt_reg - {1'b0, pop};
        if (pop)
        begin
            word0_next = word1_reg;
            last0_next = last1_reg;
        end
        if (infl_reg)
        begin
            if (kept == 2'd0)
            begin
                word0_next = tempered;
                last0_next = infl_last_reg;
            end
            else
            begin
                word1_next = tempered;
                last1_next = infl_last_reg;
            end
        end
        cnt_next = kept + {1'b0, infl_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            infl_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            infl_reg <= infl_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        infl_last_reg <= infl_last_next;
        word0_reg     <= word0_next;
        word1_reg     <= word1_next;
        last0_reg     <= last0_next;
        last1_reg     <= last1_next;
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import mtwg_pkg::*;

    // run limits, in clock cycles
    localparam int SETTLE_CYCLES = 1400;
    localparam int HOLD_CYCLES   = 2000;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              is_last;
    } gen_word_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              seed_we;
    logic [WORD_W-1:0] seed_data;

    mtwg_req_if  req_ch ();
    mtwg_word_if word_ch ();

    mersenne_twister_word_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed_data (seed_data),
        .req       (req_ch),
        .words     (word_ch)
    );

    // generator state as predicted
    logic [WORD_W-1:0] mt_state [STATE_WORDS];
    int                mt_index;
    logic [WORD_W-1:0] mt_seed;

    gen_word_t expected_words [$];

    int   gap_pct   = 0;
    int   stall_pct = 0;
    int   errors    = 0;
    int   cycles    = 0;
    int   hold_left = 0;
    logic holding;
    event hold_start;

    always #10 clk = ~clk;

    // fill the state from the seed with the multiplier recurrence
    function automatic void refill_state();
        mt_state[0] = mt_seed;
        for (int i = 1; i < STATE_WORDS; i++)
            mt_state[i] = SEED_MULT * (mt_state[i-1] ^ (mt_state[i-1] >> 30)) + 32'(i);
    endfunction

    // in-place twist of the whole state
    function automatic void twist_state();
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        for (int k = 0; k < STATE_WORDS; k++)
        begin
            y = {mt_state[k][31], mt_state[(k + 1) % STATE_WORDS][30:0]};
            v = mt_state[(k + SHIFT_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0])
                v = v ^ TWIST_XOR;
            mt_state[k] = v;
        end
    endfunction

    function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] raw);
        logic [WORD_W-1:0] t;
        t = raw ^ {11'b0, raw[31:11]};
        t = t ^ ({t[24:0], 7'b0} & TEMPER_B);
        t = t ^ ({t[16:0], 15'b0} & TEMPER_C);
        return t ^ {18'b0, t[31:18]};
    endfunction

    // next tempered word, twisting or reseeding first when due
    function automatic logic [WORD_W-1:0] next_random_word();
        if (mt_index >= STATE_WORDS)
        begin
            if (mt_index > STATE_WORDS)
                refill_state();
            twist_state();
            mt_index = 0;
        end
        mt_index++;
        return temper_word(mt_state[mt_index - 1]);
    endfunction

    // queue the words one accepted request will produce
    function automatic void predict_words(input logic [COUNT_W-1:0] count);
        int        n;
        gen_word_t w;
        n = (count > MAX_BURST) ? MAX_BURST : int'(count);
        for (int k = 0; k < n; k++)
        begin
            w.value   = next_random_word();
            w.is_last = (k == n - 1);
            expected_words.push_back(w);
        end
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    // mostly valid counts, some zero and some over-long
    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        else if (r < 10)
            return COUNT_W'($urandom_range(127, MAX_BURST + 1));
        else if (r < 25)
            return COUNT_W'($urandom_range(MAX_BURST, 48));
        return COUNT_W'($urandom_range(MAX_BURST, 1));
    endfunction

    // offer one request and wait until it is taken
    task automatic send_request(input logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.word_count <= count;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_words(count);
    endtask

    task automatic drain_words();
        req_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // seed writes only once the block has gone quiet
    task automatic write_seed(input logic [WORD_W-1:0] value);
        drain_words();
        repeat (SETTLE_CYCLES) @(posedge clk);
        seed_we   <= 1'b1;
        seed_data <= value;
        @(posedge clk);
        seed_we  <= 1'b0;
        mt_seed  = value;
        mt_index = int'(NEED_SEED);
    endtask

    task automatic test_default_seed();
        gap_pct   = 0;
        stall_pct = 0;
        send_request(7'd1);
        send_request(7'd64);
        send_request(7'd0);
        send_request(7'd127);
        send_request(7'd65);
        send_request(7'd2);
        send_request(7'd63);
        send_request(7'd3);
        drain_words();
    endtask

    // reseed part way through the state, at both seed extremes
    task automatic test_seed_extremes();
        write_seed(32'h0000_0000);
        send_request(7'd5);
        send_request(7'd64);
        write_seed(32'hffff_ffff);
        send_request(7'd1);
        send_request(7'd64);
        write_seed(SEED_DEFAULT);
        send_request(7'd2);
        drain_words();
    endtask

    // long receiver hold while full requests keep coming
    task automatic test_full_stall();
        gap_pct   = 0;
        stall_pct = 0;
        -> hold_start;
        repeat (10) send_request(7'd64);
        drain_words();
    endtask

    task automatic run_phase(input int n, input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (n) send_request(pick_count());
    endtask

    task automatic test_random_traffic();
        run_phase(40, 0, 0);
        write_seed($urandom());
        run_phase(40, 62, 0);
        run_phase(40, 0, 62);
        write_seed($urandom());
        run_phase(40, 11, 11);
        gap_pct   = 0;
        stall_pct = 0;
        drain_words();
    endtask

    // receiver ready with random stalls
    initial
    begin
        word_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            word_ch.ready <= !holding && ($urandom_range(99) >= stall_pct);
        end
    end

    // receiver hold-off, counted here
    initial
    begin
        holding <= 1'b0;
        forever
        begin
            @(hold_start);
            hold_left = HOLD_CYCLES;
            holding <= 1'b1;
            while (hold_left > 0)
            begin
                @(posedge clk);
                hold_left--;
            end
            holding <= 1'b0;
        end
    end

    // compare each delivered word with the oldest prediction
    always @(posedge clk)
    begin
        gen_word_t want;
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            if (expected_words.size() == 0)
                note_error($sformatf("unexpected word %h last %b",
                                     word_ch.random_word, word_ch.last_word));
            else
            begin
                want = expected_words.pop_front();
                if (word_ch.random_word !== want.value)
                    note_error($sformatf("random_word mismatch: expected %h got %h",
                                         want.value, word_ch.random_word));
                if (word_ch.last_word !== want.is_last)
                    note_error($sformatf("last_word mismatch: expected %b got %b (word %h)",
                                         want.is_last, word_ch.last_word, want.value));
            end
        end
    end

    // timeout
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        seed_we           <= 1'b0;
        seed_data         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.word_count <= '0;
        mt_seed  = SEED_DEFAULT;
        mt_index = int'(NEED_SEED);
        for (int i = 0; i < STATE_WORDS; i++)
            mt_state[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_seed();
        test_seed_extremes();
        test_full_stall();
        test_random_traffic();

        drain_words();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
            note_error($sformatf("%0d words never delivered", expected_words.size()));
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* mersenne_twister_word_generator_core.f */
sv/mtwg_pkg.sv
sv/mtwg_if.sv
sv/mtwg_out_buf.sv
sv/mersenne_twister_word_generator_core.sv
test/testbench.sv
